// ===== src/spq_pkg.sv =====
// ============================================================================
// spq_pkg
// Shared types and constants for the stable priority queue core.
// ============================================================================
package spq_pkg;

    // Number of entries held by the cell chain
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 5;
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;

    // Highest priority kept; larger requests are clamped to it
    localparam logic [PRIO_W-1:0] MAX_PRIORITY = PRIO_W'(16);

    // Request kinds
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell
    typedef struct packed {
        logic                       enq;
        logic                       deq;
        logic signed [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]          prio;
    } spq_cmd_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic                       occ;
        logic                       le;
        logic signed [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]          prio;
    } spq_link_t;

endpackage

// ===== src/spq_cell.sv =====
// ============================================================================
// spq_cell
// One slot of the sorted queue. Holds an entry, compares it against the
// incoming priority and moves data to or from its neighbors.
// ============================================================================
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  spq_cmd_t  cmd,
    input  spq_link_t left,
    input  spq_link_t right,
    output spq_link_t self
);

    logic                      occ_reg;
    logic                      occ_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [PRIO_W-1:0]         prio_reg;
    logic [PRIO_W-1:0]         prio_next;
    logic                      le;

    // Entry stays ahead of the new one (priority 0 always goes to the front)
    assign le = occ_reg && (cmd.prio != '0) && (prio_reg <= cmd.prio);

    // Next slot contents
    always_comb
    begin
        occ_next   = occ_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.enq)
        begin
            occ_next = left.occ;
            if (le)
            begin
                value_next = value_reg;
                prio_next  = prio_reg;
            end
            else if (left.le)
            begin
                value_next = cmd.value;
                prio_next  = cmd.prio;
            end
            else
            begin
                value_next = left.value;
                prio_next  = left.prio;
            end
        end
        else if (cmd.deq)
        begin
            occ_next   = right.occ;
            value_next = right.value;
            prio_next  = right.prio;
        end
    end

    // Occupancy is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign self.occ   = occ_reg;
    assign self.le    = le;
    assign self.value = value_reg;
    assign self.prio  = prio_reg;

endmodule

// ===== src/stable_priority_queue_core.sv =====
// ============================================================================
// stable_priority_queue_core
// Bounded priority queue built as a chain of compare-and-shift cells.
// ============================================================================
//
//  Channel  Dir  Transaction contents
//  s_*      in   tuser: req_type; tdata: in_value, in_priority
//  m_*      out  tdata: out_value, status, fill_level
//
//  One request per cycle: every cell compares and shifts in the same cycle,
//  so the result is registered at the clock edge that takes the transaction.
//  The output register frees while being taken, so s_tready stays high
//  under a steady m_tready. A stalled result holds and blocks new requests.
//  Reset empties the queue at once; no clearing pass is needed.
//
module stable_priority_queue_core
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] in_value, [36:32] in_priority, rest zero
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] out_value, [33:32] status, [38:34] fill_level
);

    logic                      accept;
    logic                      req_type;
    logic signed [VALUE_W-1:0] in_value;
    logic [PRIO_W-1:0]         in_priority;
    logic [PRIO_W-1:0]         prio_clamped;
    logic                      full;
    logic                      empty;
    spq_cmd_t                  cmd;
    spq_link_t                 links [QUEUE_DEPTH];
    spq_link_t                 head_edge;
    spq_link_t                 tail_edge;
    logic [QUEUE_DEPTH-1:0]    occ_vec;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [VALUE_W-1:0] out_value_next;
    logic [STAT_W-1:0]         status_reg;
    logic [STAT_W-1:0]         status_next;
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         fill_next;

    // Input unpacking
    assign req_type    = s_tuser;
    assign in_value    = s_tdata[VALUE_W-1:0];
    assign in_priority = s_tdata[VALUE_W+PRIO_W-1:VALUE_W];
    assign prio_clamped = (in_priority > MAX_PRIORITY) ? MAX_PRIORITY : in_priority;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign full  = links[QUEUE_DEPTH-1].occ;
    assign empty = !links[0].occ;

    // Command to the chain
    always_comb
    begin
        cmd.enq   = accept && (req_type == REQ_ENQ) && !full;
        cmd.deq   = accept && (req_type == REQ_DEQ) && !empty;
        cmd.value = in_value;
        cmd.prio  = prio_clamped;
    end

    // Boundaries: the head side looks like an occupied entry ahead of all
    assign head_edge.occ   = 1'b1;
    assign head_edge.le    = 1'b1;
    assign head_edge.value = '0;
    assign head_edge.prio  = '0;
    assign tail_edge.occ   = 1'b0;
    assign tail_edge.le    = 1'b0;
    assign tail_edge.value = '0;
    assign tail_edge.prio  = '0;

    // Cell chain, slot 0 is the head
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  ((i == 0) ? head_edge : links[(i == 0) ? 0 : i - 1]),
            .right ((i == QUEUE_DEPTH - 1) ? tail_edge
                                            : links[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .self  (links[i])
        );
        assign occ_vec[i] = links[i].occ;
    end

    // Result and count
    always_comb
    begin
        count_next     = count_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            status_next    = ST_DONE;
            if (req_type == REQ_ENQ)
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    out_value_next = links[0].value;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
        end
        fill_next = accept ? FILL_W'(count_next) : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        fill_reg      <= fill_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, fill_reg, status_reg, out_value_reg};

    // Priorities along the occupied part of the chain never decrease
    logic sorted_ok;
    always_comb
    begin
        sorted_ok = 1'b1;
        for (int k = 1; k < QUEUE_DEPTH; k++)
        begin
            if (links[k].occ && (links[k].prio < links[k-1].prio))
                sorted_ok = 1'b0;
        end
    end

    // Checks
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == 32'(count_reg))
        else $error("cell occupancy disagrees with count");

    a_occ_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec & (occ_vec + 1'b1)) == '0))
        else $error("occupied cells are not a contiguous head run");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("queue priorities out of order");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.enq == 1'b0 && accept && req_type == REQ_ENQ) |=> (status_reg == ST_FULL))
        else $error("dropped enqueue not flagged full");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted request gave no result");

endmodule

// ===== tb/sv/spq_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// spq_checker
// Watches both stream channels of the priority queue core. Keeps its own
// sorted copy of the queue, works out the result of every accepted request
// and compares each accepted result with the oldest one still awaited.
// ============================================================================
module spq_checker
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] in_value, [36:32] in_priority, rest zero
    input  logic        s_tuser,   // [0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] out_value, [33:32] status, [38:34] fill_level
    output int          fail_count,
    output int          awaited_count,
    output int          results_seen,
    output int          full_drops,
    output int          empty_reads
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STAT_W-1:0]         status;
        logic [FILL_W-1:0]         fill;
    } spq_result_t;

    // Shadow copy of the queue, slot 0 is the head
    logic signed [VALUE_W-1:0] shadow_value [QUEUE_DEPTH];
    logic [PRIO_W-1:0]         shadow_prio  [QUEUE_DEPTH];
    int                        shadow_count;

    spq_result_t awaited_results [$];

    // Apply one request to the shadow queue and return its result
    function automatic spq_result_t apply_request(input logic req,
                                                  input logic signed [VALUE_W-1:0] val,
                                                  input logic [PRIO_W-1:0] prio_req);
        spq_result_t       res;
        logic [PRIO_W-1:0] prio;
        int                pos;
        res.value  = '0;
        res.status = ST_DONE;
        prio       = (prio_req > MAX_PRIORITY) ? MAX_PRIORITY : prio_req;
        pos        = 0;
        if (req == REQ_ENQ) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
                full_drops++;
            end
            else begin
                // priority 0 jumps the line, others go behind their equals
                if (prio != '0) begin
                    while (pos < shadow_count && shadow_prio[pos] <= prio)
                        pos++;
                end
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = val;
                shadow_prio[pos]  = prio;
                shadow_count++;
            end
        end
        else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
                empty_reads++;
            end
            else begin
                res.value = shadow_value[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_prio[i-1]  = shadow_prio[i];
                end
                shadow_count--;
            end
        end
        res.fill = FILL_W'(shadow_count);
        return res;
    endfunction

    // Results are checked before the request of the same cycle is predicted
    always @(posedge clk or negedge rst_n) begin
        spq_result_t want;
        spq_result_t got;
        if (!rst_n) begin
            shadow_count = 0;
            fail_count   = 0;
            results_seen = 0;
            full_drops   = 0;
            empty_reads  = 0;
            awaited_results.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.value  = m_tdata[31:0];
                got.status = m_tdata[33:32];
                got.fill   = m_tdata[38:34];
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, actual value %h status %0d fill %0d",
                             $time, got.value, got.status, got.fill);
                    fail_count++;
                end
                else begin
                    want = awaited_results.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t: out_value mismatch, expected %h actual %h",
                                 $time, want.value, got.value);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.fill !== want.fill) begin
                        $display("%0t: fill_level mismatch, expected %0d actual %0d",
                                 $time, want.fill, got.fill);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_request(s_tuser, s_tdata[31:0],
                                                        s_tdata[36:32]));
        end
        awaited_count = awaited_results.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus and verdict for the stable priority queue core. Sends a directed
// set of requests, then random epochs biased toward filling, emptying or
// balance, with random idle gaps on both channels; the checker does the comparing.
// ============================================================================
module testbench;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1630;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 100;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [31:0] in_value, [36:32] in_priority, rest zero
    logic        s_tuser  = 1'b0; // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [31:0] out_value, [33:32] status, [38:34] fill_level

    int fail_count;
    int awaited_count;
    int results_seen;
    int full_drops;
    int empty_reads;
    int requests_sent = 0;
    int idle_cycles   = 0;
    bit sender_gaps   = 1'b1;

    stable_priority_queue_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    spq_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .awaited_count (awaited_count),
        .results_seen  (results_seen),
        .full_drops    (full_drops),
        .empty_reads   (empty_reads)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // Offer one request and hold it until the transaction is taken
    task automatic send_request(input logic req, input logic [VALUE_W-1:0] val,
                                input logic [PRIO_W-1:0] prio);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, prio, val};
        s_tuser  <= req;
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    // Stop offering until every awaited result has come back
    task automatic drain_queue();
        s_tvalid <= 1'b0;
        while (awaited_count != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [PRIO_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return PRIO_W'($urandom_range(1, 4));
        else if (r < 65)
            return '0;
        else if (r < 80)
            return PRIO_W'($urandom_range(0, 31));
        else
            return PRIO_W'($urandom_range(5, 16));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 39))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random idling in stretches, one long hold-off to back up the input
    initial begin
        int gap;
        int stretch;
        bit always_ready;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            always_ready = ($urandom_range(0, 2) == 0);
            stretch      = $urandom_range(20, 80);
            repeat (stretch) begin
                if (!held && results_seen >= 400) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    held = 1'b1;
                end
                gap = always_ready ? 0 : pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run if nothing moves on either channel for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus and verdict
    initial begin
        int epoch_len;
        int enq_pct;
        int sent_random;
        logic req;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty read, stable insert order, clamping, full drop
        send_request(REQ_DEQ, 32'h0000_0000, 5'd0);
        send_request(REQ_ENQ, 32'h7FFF_FFFF, 5'd5);
        send_request(REQ_ENQ, 32'h8000_0000, 5'd5);
        send_request(REQ_ENQ, 32'h0000_0000, 5'd0);
        send_request(REQ_ENQ, 32'hFFFF_FFFF, 5'd0);
        send_request(REQ_ENQ, 32'h1234_5678, 5'd16);
        send_request(REQ_ENQ, 32'h0BAD_F00D, 5'd17);
        send_request(REQ_ENQ, 32'h5A5A_5A5A, 5'd31);
        send_request(REQ_ENQ, 32'hA5A5_A5A5, 5'd1);
        send_request(REQ_ENQ, 32'h0000_0003, 5'd3);
        send_request(REQ_ENQ, 32'h0000_0033, 5'd3);
        send_request(REQ_ENQ, 32'h0000_0002, 5'd2);
        send_request(REQ_ENQ, 32'hDEAD_BEEF, 5'd16);
        send_request(REQ_ENQ, 32'h0000_0004, 5'd4);
        send_request(REQ_ENQ, 32'h0000_0008, 5'd8);
        send_request(REQ_ENQ, 32'h0000_000C, 5'd12);
        send_request(REQ_ENQ, 32'hC001_D00D, 5'd1);
        send_request(REQ_ENQ, 32'h1111_1111, 5'd0);
        repeat (4) send_request(REQ_DEQ, 32'hFFFF_FFFF, 5'd31);
        drain_queue();

        // Random epochs, each biased toward enqueue, dequeue or balance
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            epoch_len   = $urandom_range(30, 90);
            sender_gaps = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            repeat (epoch_len) begin
                if (sent_random == RANDOM_ITEMS / 2)
                    drain_queue();
                req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                send_request(req, pick_value(), pick_priority());
                sent_random++;
            end
        end
        s_tvalid <= 1'b0;

        // Wait for every remaining result to come back
        while (awaited_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d requests, checked %0d results.", requests_sent, results_seen);
        $display("Full-queue drops: %0d, empty-queue dequeues: %0d.",
                 full_drops, empty_reads);
        if (fail_count == 0 && awaited_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue_core.sv
tb/sv/spq_checker.sv
tb/sv/testbench.sv
